/* hdl/timeline_window_event_generator_defines.svh */
// ---------------------------------------------------------------------------
// timeline window event generator assertion macros
// concurrent checks, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef TIMELINE_WINDOW_EVENT_GENERATOR_DEFINES_SVH
`define TIMELINE_WINDOW_EVENT_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define TWE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("twe check failed");
// antecedent implies consequent in the next cycle
`define TWE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("twe check failed");
// condition never holds
`define TWE_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("twe check failed");
`else
`define TWE_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define TWE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define TWE_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

/* hdl/twe_pkg.sv */
// ---------------------------------------------------------------------------
// twe_pkg
// shared types and constants of the timeline window event generator
// ---------------------------------------------------------------------------
package twe_pkg;

   localparam int TIME_W      = 32;
   localparam int SPAN_W      = 31;
   localparam int SPEED_W     = 16;
   localparam int EVENT_DEPTH = 16;
   localparam int CNT_W       = 5;
   localparam int WINDOWS_DEF = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 31;

   localparam logic [SPEED_W-1:0] SPEED_ONE = 16'd4096;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOOP_MODE      = 3'd0,
      CSR_CYCLE_LENGTH   = 3'd1,
      CSR_WINDOWS_IN_USE = 3'd2,
      CSR_EVENT_LIMIT    = 3'd3,
      CSR_TIME_SCALE     = 3'd4
   } twe_csr_idx_type;

   typedef enum logic [1:0] {
      EV_ENTER = 2'd0,
      EV_EXIT  = 2'd1,
      EV_NONE  = 2'd2
   } twe_evkind_type;

   typedef struct packed {
      logic                 loop_mode;
      logic [SPAN_W-1:0]    cycle_length;
      logic [3:0]           windows_in_use;
      logic [CNT_W-1:0]     event_limit;
      logic [SPEED_W-1:0]   time_scale;
   } twe_cfg_type;

   // queue entry: a scaled query or a table load
   typedef struct packed {
      logic              is_load;
      logic [2:0]        slot;
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
   } twe_item_type;

   typedef struct packed {
      twe_evkind_type    kind;
      logic [2:0]        win;
      logic [TIME_W-1:0] etime;
   } twe_event_type;

   typedef enum logic [2:0] {
      F_IDLE, F_MUL_P, F_MUL_C, F_SAT_C, F_PUSH
   } twe_front_state_type;

   typedef enum logic [2:0] {
      B_IDLE, B_MOD, B_WALK, B_OUT, B_NONE
   } twe_back_state_type;

endpackage

/* hdl/twe_channels.sv */
// ---------------------------------------------------------------------------
// twe channel interfaces
// request, response and register write channels
// ---------------------------------------------------------------------------
interface twe_req_if;
   logic                           valid;
   logic                           ready;
   logic                           kind;
   logic signed [31:0]             prev_time;
   logic signed [31:0]             curr_time;
   logic [2:0]                     slot;
   logic [twe_pkg::SPAN_W-1:0]     window_start;
   logic [twe_pkg::SPAN_W-1:0]     window_length;
   modport source (output valid, kind, prev_time, curr_time, slot, window_start,
                   window_length, input ready);
   modport sink   (input valid, kind, prev_time, curr_time, slot, window_start,
                   window_length, output ready);
endinterface

interface twe_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  event_kind;
   logic [2:0]                  event_window;
   logic [twe_pkg::TIME_W-1:0]  event_time;
   logic                        last;
   modport source (output valid, event_kind, event_window, event_time, last,
                   input ready);
   modport sink   (input valid, event_kind, event_window, event_time, last,
                   output ready);
endinterface

interface twe_csr_if;
   logic                            valid;
   logic                            ready;
   logic [twe_pkg::CSR_IDX_W-1:0]   index;
   logic [twe_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/timeline_window_event_generator.sv */
// ---------------------------------------------------------------------------
// timeline_window_event_generator
// window edge events for a time query, sorted by time, enter before exit
// ---------------------------------------------------------------------------
// channel  direction  carries
// req_ch   in         time query or window table load
// rsp_ch   out        one event per transfer, last marks the query end
// csr_ch   in         register index and write data
//
// a load or a query passes the front part (a load: idle, push; a query: idle,
// mul_p, mul_c, sat_c, push, with one shared multiplier scaling both times);
// the back part stores a load in the window table and, for a query, examines
// the enter and exit edge of each window in use, giving one result per event
// (a single no-event result when nothing fires); loop mode first takes the
// bit-serial remainder of both times. queries are handled one at a time.
// reset is synchronous and clears the window table and all control state.
// a stalled rsp_ch holds the back part; the front fills its two-entry queue.
// ---------------------------------------------------------------------------
module timeline_window_event_generator #(
   parameter int WINDOWS = twe_pkg::WINDOWS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   twe_req_if.sink    req_ch,
   twe_rsp_if.source  rsp_ch,
   twe_csr_if.sink    csr_ch
);

   twe_pkg::twe_cfg_type   cfg_ff, cfg_in;
   twe_pkg::twe_item_type  push_data, pop_data;
   twe_pkg::twe_event_type rsp_data;
   logic                   push_valid, push_ready, pop_valid, pop_ready;

   // register writes
   assign csr_ch.ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            twe_pkg::CSR_LOOP_MODE:      cfg_in.loop_mode      = csr_ch.data[0];
            twe_pkg::CSR_CYCLE_LENGTH:   cfg_in.cycle_length   = csr_ch.data;
            twe_pkg::CSR_WINDOWS_IN_USE: cfg_in.windows_in_use = csr_ch.data[3:0];
            twe_pkg::CSR_EVENT_LIMIT:    cfg_in.event_limit    = csr_ch.data[4:0];
            twe_pkg::CSR_TIME_SCALE:     cfg_in.time_scale     = csr_ch.data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.loop_mode      <= 1'b0;
         cfg_ff.cycle_length   <= '0;
         cfg_ff.windows_in_use <= '0;
         cfg_ff.event_limit    <= twe_pkg::CNT_W'(twe_pkg::EVENT_DEPTH);
         cfg_ff.time_scale     <= twe_pkg::SPEED_ONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   twe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .speed      (cfg_ff.time_scale),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   twe_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   twe_back #(.WINDOWS(WINDOWS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_data  (rsp_data),
      .rsp_last  (rsp_ch.last)
   );

   // result payload
   assign rsp_ch.event_kind   = rsp_data.kind;
   assign rsp_ch.event_window = rsp_data.win;
   assign rsp_ch.event_time   = rsp_data.etime;

endmodule

/* hdl/twe_front.sv */
// ---------------------------------------------------------------------------
// twe_front
// accepts requests, scales query times by the playback speed, queues items
// ---------------------------------------------------------------------------
module twe_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [twe_pkg::SPEED_W-1:0] speed,
   twe_req_if.sink                     req,
   output logic                        push_valid,
   input  logic                        push_ready,
   output twe_pkg::twe_item_type       push_data
);

   localparam int PROD_W = twe_pkg::SPAN_W + twe_pkg::SPEED_W;

   twe_pkg::twe_front_state_type state_ff, state_in;
   twe_pkg::twe_item_type        item_ff, item_in;
   logic [PROD_W-1:0]            prod_ff, prod_in;
   logic [twe_pkg::SPAN_W-1:0]   mul_op;
   logic [twe_pkg::SPEED_W-1:0]  spd;

   // drop fraction, clamp negative to zero, saturate
   function automatic logic [twe_pkg::TIME_W-1:0] sat_time(input logic [PROD_W-1:0] p,
                                                          input logic neg);
      logic [PROD_W-13:0] v;
      v = p[PROD_W-1:12];
      if (neg)
         return '0;
      else if (v[PROD_W-13:twe_pkg::TIME_W] != '0)
         return '1;
      else
         return v[twe_pkg::TIME_W-1:0];
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         twe_pkg::F_IDLE: begin
            if (req.valid)
               state_in = req.kind ? twe_pkg::F_PUSH : twe_pkg::F_MUL_P;
         end
         twe_pkg::F_MUL_P: state_in = twe_pkg::F_MUL_C;
         twe_pkg::F_MUL_C: state_in = twe_pkg::F_SAT_C;
         twe_pkg::F_SAT_C: state_in = twe_pkg::F_PUSH;
         twe_pkg::F_PUSH: begin
            if (push_ready)
               state_in = twe_pkg::F_IDLE;
         end
         default: state_in = twe_pkg::F_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req.ready  = (state_ff == twe_pkg::F_IDLE);
      push_valid = (state_ff == twe_pkg::F_PUSH);
      push_data  = item_ff;
   end

   // shared multiplier
   assign spd     = (speed == '0) ? twe_pkg::SPEED_ONE : speed;
   assign mul_op  = (state_ff == twe_pkg::F_MUL_P) ? item_ff.a[twe_pkg::SPAN_W-1:0]
                                                   : item_ff.b[twe_pkg::SPAN_W-1:0];

   // datapath
   always_comb begin
      item_in = item_ff;
      prod_in = prod_ff;
      case (state_ff)
         twe_pkg::F_IDLE: begin
            item_in.is_load = req.kind;
            item_in.slot    = req.slot;
            item_in.a       = req.kind ? {1'b0, req.window_start} : req.prev_time;
            item_in.b       = req.kind ? {1'b0, req.window_length} : req.curr_time;
         end
         twe_pkg::F_MUL_P: prod_in = PROD_W'(mul_op) * PROD_W'(spd);
         twe_pkg::F_MUL_C: begin
            item_in.a = sat_time(prod_ff, item_ff.a[twe_pkg::TIME_W-1]);
            prod_in   = PROD_W'(mul_op) * PROD_W'(spd);
         end
         twe_pkg::F_SAT_C: item_in.b = sat_time(prod_ff, item_ff.b[twe_pkg::TIME_W-1]);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= twe_pkg::F_IDLE;
      else
         state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      prod_ff <= prod_in;
   end

endmodule

/* hdl/twe_fifo.sv */
// ---------------------------------------------------------------------------
// twe_fifo
// two-entry queue between the front and back parts
// ---------------------------------------------------------------------------
module twe_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  twe_pkg::twe_item_type push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output twe_pkg::twe_item_type pop_data
);

   twe_pkg::twe_item_type entry_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* hdl/twe_back.sv */
// ---------------------------------------------------------------------------
// twe_back
// window table, loop modulo, window walk, sorted event list and output
// ---------------------------------------------------------------------------
`include "timeline_window_event_generator_defines.svh"

module twe_back #(
   parameter int WINDOWS = twe_pkg::WINDOWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  twe_pkg::twe_cfg_type  cfg,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  twe_pkg::twe_item_type pop_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output twe_pkg::twe_event_type rsp_data,
   output logic                  rsp_last
);

   localparam int WIN_W  = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
   localparam int WCNT_W = $clog2(WINDOWS + 1);
   localparam int TW     = twe_pkg::TIME_W;
   localparam int DEPTH  = twe_pkg::EVENT_DEPTH;
   localparam int CW     = twe_pkg::CNT_W;

   twe_pkg::twe_back_state_type state_ff, state_in;

   logic [twe_pkg::SPAN_W-1:0] start_ff [WINDOWS];
   logic [twe_pkg::SPAN_W-1:0] len_ff   [WINDOWS];

   logic [TW-1:0]      p_ff, p_in, c_ff, c_in;
   logic [TW-1:0]      xp_ff, xp_in, xc_ff, xc_in;
   logic [4:0]         bit_ff, bit_in;
   logic               loop_ff, loop_in;
   logic [WCNT_W-1:0]  w_ff, w_in, nwin_ff, nwin_in;
   logic               ph_ff, ph_in;
   logic [CW-1:0]      n_ff, n_in, lim_ff, lim_in;

   twe_pkg::twe_event_type cell_ff [DEPTH];
   twe_pkg::twe_event_type cell_in [DEPTH];
   twe_pkg::twe_event_type key;
   logic [DEPTH-1:0]       gt;

   logic               take_item, do_load, looping_now, out_xfer;
   logic               walk_done, wrapped, fire, insert;
   logic [WIN_W-1:0]   widx, lidx;
   logic [TW-1:0]      st, en, edge_t, cyc;
   logic [TW-1:0]      rp_sh, rc_sh;
   logic [twe_pkg::SPAN_W-1:0] len_w;

   assign take_item   = pop_valid && pop_ready;
   assign do_load     = take_item && pop_data.is_load && (32'(pop_data.slot) < WINDOWS);
   assign looping_now = cfg.loop_mode && (cfg.cycle_length != '0);
   assign out_xfer    = rsp_valid && rsp_ready;
   assign cyc         = {1'b0, cfg.cycle_length};

   // current window edge
   assign widx    = w_ff[WIN_W-1:0];
   assign lidx    = WIN_W'(pop_data.slot);
   assign len_w   = len_ff[widx];
   assign st      = {1'b0, start_ff[widx]};
   assign en      = st + {1'b0, len_w};
   assign edge_t  = ph_ff ? en : st;
   assign wrapped = loop_ff && (c_ff < p_ff);
   assign walk_done = (w_ff == nwin_ff);
   always_comb begin
      if (len_w == '0)
         fire = 1'b0;
      else if (wrapped)
         fire = ((edge_t > p_ff) && (edge_t < cyc)) || (edge_t <= c_ff);
      else
         fire = (edge_t > p_ff) && (edge_t <= c_ff);
   end
   assign insert = (state_ff == twe_pkg::B_WALK) && !walk_done && fire && (n_ff < lim_ff);

   assign key.kind  = ph_ff ? twe_pkg::EV_EXIT : twe_pkg::EV_ENTER;
   assign key.win   = 3'(w_ff);
   assign key.etime = edge_t;

   // one restoring step per lane
   assign rp_sh = {p_ff[TW-2:0], xp_ff[TW-1]};
   assign rc_sh = {c_ff[TW-2:0], xc_ff[TW-1]};

   // cells ahead of which the new event goes
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (CW'(i) < n_ff)
            gt[i] = (cell_ff[i].etime > key.etime) ||
                    ((cell_ff[i].etime == key.etime) && (cell_ff[i].kind > key.kind));
         else
            gt[i] = 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         twe_pkg::B_IDLE: begin
            if (pop_valid && !pop_data.is_load)
               state_in = looping_now ? twe_pkg::B_MOD : twe_pkg::B_WALK;
         end
         twe_pkg::B_MOD: begin
            if (bit_ff == 5'd31)
               state_in = twe_pkg::B_WALK;
         end
         twe_pkg::B_WALK: begin
            if (walk_done)
               state_in = (n_ff == '0) ? twe_pkg::B_NONE : twe_pkg::B_OUT;
         end
         twe_pkg::B_OUT: begin
            if (rsp_ready && (n_ff == CW'(1)))
               state_in = twe_pkg::B_IDLE;
         end
         twe_pkg::B_NONE: begin
            if (rsp_ready)
               state_in = twe_pkg::B_IDLE;
         end
         default: state_in = twe_pkg::B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop_ready = (state_ff == twe_pkg::B_IDLE);
      rsp_valid = (state_ff inside {twe_pkg::B_OUT, twe_pkg::B_NONE});
      if (state_ff == twe_pkg::B_NONE) begin
         rsp_data.kind  = twe_pkg::EV_NONE;
         rsp_data.win   = '0;
         rsp_data.etime = '0;
         rsp_last       = 1'b1;
      end else begin
         rsp_data = cell_ff[0];
         rsp_last = (n_ff == CW'(1));
      end
   end

   // datapath
   always_comb begin
      p_in = p_ff;  c_in = c_ff;  xp_in = xp_ff;  xc_in = xc_ff;
      bit_in = bit_ff;  loop_in = loop_ff;  w_in = w_ff;  ph_in = ph_ff;
      n_in = n_ff;  lim_in = lim_ff;  nwin_in = nwin_ff;
      cell_in = cell_ff;
      case (state_ff)
         twe_pkg::B_IDLE: begin
            if (take_item && !pop_data.is_load) begin
               loop_in = looping_now;
               w_in    = '0;
               ph_in   = 1'b0;
               n_in    = '0;
               bit_in  = '0;
               lim_in  = (cfg.event_limit > CW'(DEPTH)) ? CW'(DEPTH) : cfg.event_limit;
               nwin_in = (32'(cfg.windows_in_use) > WINDOWS) ? WCNT_W'(WINDOWS)
                                                            : WCNT_W'(cfg.windows_in_use);
               if (looping_now) begin
                  xp_in = pop_data.a;
                  xc_in = pop_data.b;
                  p_in  = '0;
                  c_in  = '0;
               end else if (pop_data.b < pop_data.a) begin
                  p_in = pop_data.b;
                  c_in = pop_data.a;
               end else begin
                  p_in = pop_data.a;
                  c_in = pop_data.b;
               end
            end
         end
         twe_pkg::B_MOD: begin
            p_in   = (rp_sh >= cyc) ? rp_sh - cyc : rp_sh;
            c_in   = (rc_sh >= cyc) ? rc_sh - cyc : rc_sh;
            xp_in  = {xp_ff[TW-2:0], 1'b0};
            xc_in  = {xc_ff[TW-2:0], 1'b0};
            bit_in = bit_ff + 5'd1;
         end
         twe_pkg::B_WALK: begin
            if (!walk_done) begin
               ph_in = ~ph_ff;
               if (ph_ff)
                  w_in = w_ff + WCNT_W'(1);
               if (insert) begin
                  n_in = n_ff + CW'(1);
                  if (gt[0])
                     cell_in[0] = key;
                  for (int i = 1; i < DEPTH; i++) begin
                     if (gt[i])
                        cell_in[i] = gt[i-1] ? cell_ff[i-1] : key;
                  end
               end
            end
         end
         twe_pkg::B_OUT: begin
            if (out_xfer) begin
               n_in = n_ff - CW'(1);
               for (int i = 0; i < DEPTH - 1; i++)
                  cell_in[i] = cell_ff[i+1];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= twe_pkg::B_IDLE;
      else
         state_ff <= state_in;
   end

   // window table, all windows disabled after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOWS; i++) begin
            start_ff[i] <= '0;
            len_ff[i]   <= '0;
         end
      end else if (do_load) begin
         start_ff[lidx] <= pop_data.a[twe_pkg::SPAN_W-1:0];
         len_ff[lidx]   <= pop_data.b[twe_pkg::SPAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
      end else begin
         n_ff <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      c_ff    <= c_in;
      xp_ff   <= xp_in;
      xc_ff   <= xc_in;
      bit_ff  <= bit_in;
      loop_ff <= loop_in;
      w_ff    <= w_in;
      ph_ff   <= ph_in;
      lim_ff  <= lim_in;
      nwin_ff <= nwin_in;
      cell_ff <= cell_in;
   end

   // checks
   `TWE_ASSERT_NEVER(a_count_bound, clock, reset, n_ff > CW'(DEPTH))
   `TWE_ASSERT_SAME(a_out_has_event, clock, reset, state_ff == twe_pkg::B_OUT, n_ff != '0)
   `TWE_ASSERT_SAME(a_mod_reduced, clock, reset, (state_ff == twe_pkg::B_WALK) && loop_ff, (p_ff < cyc) && (c_ff < cyc))
   `TWE_ASSERT_NEXT(a_none_then_idle, clock, reset, (state_ff == twe_pkg::B_NONE) && rsp_ready, state_ff == twe_pkg::B_IDLE)

endmodule

/* sim/twe_event_checker.sv */
// ---------------------------------------------------------------------------
// twe event checker
// watches the request, response and register channels of the timeline
// window event generator, predicts the events of each query and compares
// ---------------------------------------------------------------------------
module twe_event_checker (
   input  logic clock,
   input  logic reset,
   twe_req_if   req_mon,
   twe_rsp_if   rsp_mon,
   twe_csr_if   csr_mon,
   output int   fail_count,
   output int   pending_events
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NWIN = 8;

   // shadow of the registers and the window table
   logic                       loop_q;
   logic [twe_pkg::SPAN_W-1:0] cycle_q;
   logic [3:0]                 nwin_q;
   logic [twe_pkg::CNT_W-1:0]  limit_q;
   logic [15:0]                scale_q;
   logic [30:0]                start_q [NWIN];
   logic [30:0]                len_q   [NWIN];

   twe_pkg::twe_event_type expected_events [$];

   assign pending_events = expected_events.size();

   function automatic logic [32:0] scaled(logic [31:0] raw);
      logic [47:0] prod;
      logic [15:0] spd;
      begin
         spd = (scale_q == '0) ? twe_pkg::SPEED_ONE : scale_q;
         if (raw[31]) return 33'd0;
         prod = ({17'd0, raw[30:0]} * {32'd0, spd}) >> 12;
         if (prod > 48'hFFFF_FFFF) return 33'h0_FFFF_FFFF;
         return prod[32:0];
      end
   endfunction

   // compute the sorted event list of one query
   task automatic predict_query(logic [31:0] pt, logic [31:0] ct);
      logic [32:0]            p, c, tmp, st, en;
      logic                   looping, wrapped, fe, fx;
      int                     limit, nw, n, j;
      twe_pkg::twe_event_type evs [$];
      twe_pkg::twe_event_type key;
      begin
         limit = (limit_q > 5'd16) ? 16 : int'(limit_q);
         nw = (int'(nwin_q) > NWIN) ? NWIN : int'(nwin_q);
         p = scaled(pt);
         c = scaled(ct);
         looping = loop_q && cycle_q != '0;
         wrapped = 1'b0;
         if (!looping) begin
            if (c < p) begin
               tmp = p; p = c; c = tmp;
            end
         end else begin
            if (p >= 33'(cycle_q)) p = p % 33'(cycle_q);
            if (c >= 33'(cycle_q)) c = c % 33'(cycle_q);
            wrapped = c < p;
         end
         for (int i = 0; i < nw; i++) begin
            if (len_q[i] != '0) begin
               st = 33'(start_q[i]);
               en = st + 33'(len_q[i]);
               if (!wrapped) begin
                  fe = st > p && st <= c;
                  fx = en > p && en <= c;
               end else begin
                  fe = (st > p && st < 33'(cycle_q)) || st <= c;
                  fx = (en > p && en < 33'(cycle_q)) || en <= c;
               end
               if (fe && evs.size() < limit)
                  evs.push_back('{twe_pkg::EV_ENTER, i[2:0], st[31:0]});
               if (fx && evs.size() < limit)
                  evs.push_back('{twe_pkg::EV_EXIT, i[2:0], en[31:0]});
            end
         end
         // stable insertion sort, enter before exit on equal times
         n = evs.size();
         for (int i = 1; i < n; i++) begin
            key = evs[i];
            j = i;
            while (j > 0 && (evs[j-1].etime > key.etime ||
                  (evs[j-1].etime == key.etime && evs[j-1].kind > key.kind))) begin
               evs[j] = evs[j-1];
               j--;
            end
            evs[j] = key;
         end
         if (n == 0) expected_events.push_back('{twe_pkg::EV_NONE, 3'd0, 32'd0});
         foreach (evs[i]) expected_events.push_back(evs[i]);
      end
   endtask

   // last flag is derived from position: mark query ends alongside events
   bit expected_last [$];

   always @(posedge clock) begin
      if (reset) begin
         loop_q  <= 1'b0;
         cycle_q <= '0;
         nwin_q  <= '0;
         limit_q <= 5'd16;
         scale_q <= twe_pkg::SPEED_ONE;
         for (int i = 0; i < NWIN; i++) begin
            start_q[i] = '0;
            len_q[i]   = '0;
         end
         expected_events.delete();
         expected_last.delete();
         fail_count <= 0;
      end else begin
         // register write transfer
         if (csr_mon.valid && csr_mon.ready) begin
            case (twe_pkg::twe_csr_idx_type'(csr_mon.index))
               twe_pkg::CSR_LOOP_MODE:      loop_q  <= csr_mon.data[0];
               twe_pkg::CSR_CYCLE_LENGTH:   cycle_q <= csr_mon.data[30:0];
               twe_pkg::CSR_WINDOWS_IN_USE: nwin_q  <= csr_mon.data[3:0];
               twe_pkg::CSR_EVENT_LIMIT:    limit_q <= csr_mon.data[4:0];
               twe_pkg::CSR_TIME_SCALE:     scale_q <= csr_mon.data[15:0];
               default: ;
            endcase
         end
         // request transfer
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.kind) begin
               start_q[req_mon.slot] = req_mon.window_start;
               len_q[req_mon.slot]   = req_mon.window_length;
            end else begin
               int before_n;
               before_n = expected_events.size();
               predict_query(req_mon.prev_time, req_mon.curr_time);
               for (int i = before_n; i < expected_events.size(); i++)
                  expected_last.push_back(i == expected_events.size() - 1);
            end
         end
         // response transfer
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_events.size() == 0) begin
               $error("unexpected event: kind %0d window %0d time %0d",
                  rsp_mon.event_kind, rsp_mon.event_window, rsp_mon.event_time);
               fail_count <= fail_count + 1;
            end else begin
               twe_pkg::twe_event_type exp_ev;
               bit                     exp_last;
               int                     bad;
               exp_ev = expected_events.pop_front();
               exp_last = expected_last.pop_front();
               bad = 0;
               if (rsp_mon.event_kind !== exp_ev.kind) begin
                  $error("event_kind expected %0d actual %0d", exp_ev.kind, rsp_mon.event_kind);
                  bad++;
               end
               if (rsp_mon.event_window !== exp_ev.win) begin
                  $error("event_window expected %0d actual %0d", exp_ev.win,
                     rsp_mon.event_window);
                  bad++;
               end
               if (rsp_mon.event_time !== exp_ev.etime) begin
                  $error("event_time expected %0d actual %0d", exp_ev.etime,
                     rsp_mon.event_time);
                  bad++;
               end
               if (rsp_mon.last !== exp_last) begin
                  $error("last expected %0d actual %0d", exp_last, rsp_mon.last);
                  bad++;
               end
               if (bad != 0) fail_count <= fail_count + 1;
            end
         end
      end
   end
endmodule

/* sim/tb_timeline_window_event_generator.sv */
// ---------------------------------------------------------------------------
// tb_timeline_window_event_generator
// drives window loads, time queries and register writes through several
// settings and idling phases; the checker predicts and compares events
// ---------------------------------------------------------------------------
module tb_timeline_window_event_generator;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_events;
   int   send_idle_pct;
   int   recv_stall_pct;

   twe_req_if req_ch ();
   twe_rsp_if rsp_ch ();
   twe_csr_if csr_ch ();

   timeline_window_event_generator uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   twe_event_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_mon        (csr_ch),
      .fail_count     (fail_count),
      .pending_events (pending_events)
   );

   always #5 clock = ~clock;

   // receiver stalls
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // one register write transfer; valid stays up until the next driver call
   task automatic write_reg(twe_pkg::twe_csr_idx_type idx, logic [30:0] value);
      begin
         req_ch.valid <= 1'b0;
         csr_ch.valid <= 1'b1;
         csr_ch.index <= idx;
         csr_ch.data  <= value;
         do @(posedge clock); while (!csr_ch.ready);
      end
   endtask

   // one request transfer; valid stays up until the next driver call
   task automatic send_item(logic kind, logic [31:0] pt, logic [31:0] ct, logic [2:0] slot,
                            logic [30:0] ws, logic [30:0] wl);
      begin
         csr_ch.valid <= 1'b0;
         while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
         req_ch.valid         <= 1'b1;
         req_ch.kind          <= kind;
         req_ch.prev_time     <= pt;
         req_ch.curr_time     <= ct;
         req_ch.slot          <= slot;
         req_ch.window_start  <= ws;
         req_ch.window_length <= wl;
         do @(posedge clock); while (!req_ch.ready);
      end
   endtask

   // wait until every expected event has come, then let the block settle
   task automatic drain;
      begin
         req_ch.valid <= 1'b0;
         csr_ch.valid <= 1'b0;
         @(posedge clock);
         while (pending_events != 0) @(posedge clock);
         repeat (100) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] rand_time(int span);
      int r;
      begin
         r = int'($urandom_range(9));
         if (r == 0) return $urandom;
         if (r == 1) return 32'h8000_0000 | $urandom;
         return 32'($urandom_range(span));
      end
   endfunction

   task automatic load_random_windows(int span);
      begin
         for (int s = 0; s < 8; s++)
            send_item(1'b1, $urandom, $urandom, s[2:0], 31'($urandom_range(span)),
               31'(($urandom_range(7) == 0) ? 0 : $urandom_range(span / 2 + 1)));
      end
   endtask

   initial begin
      #20ms;
      $display("timeline_window_event_generator regression: fail");
      $finish;
   end

   initial begin
      int span;
      req_ch.valid = 1'b0;
      req_ch.kind = 1'b0;
      req_ch.prev_time = '0;
      req_ch.curr_time = '0;
      req_ch.slot = '0;
      req_ch.window_start = '0;
      req_ch.window_length = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: query with no windows in use, then table extremes
      send_item(1'b0, 32'd0, 32'd100, 3'd0, 31'd0, 31'd0);
      drain();
      write_reg(twe_pkg::CSR_WINDOWS_IN_USE, 31'd15);
      send_item(1'b1, 32'd0, 32'd0, 3'd0, 31'd10, 31'd20);
      send_item(1'b1, 32'd0, 32'd0, 3'd1, 31'd10, 31'd0);
      send_item(1'b1, 32'd0, 32'd0, 3'd2, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_item(1'b1, 32'd0, 32'd0, 3'd3, 31'd30, 31'd5);
      send_item(1'b1, 32'd0, 32'd0, 3'd7, 31'd0, 31'd30);
      send_item(1'b0, 32'd0, 32'd40, 3'd0, 31'd0, 31'd0);
      send_item(1'b0, 32'd40, 32'd0, 3'd0, 31'd0, 31'd0);
      send_item(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 3'd0, 31'd0, 31'd0);
      send_item(1'b0, 32'hFFFF_FFFF, 32'd30, 3'd0, 31'd0, 31'd0);
      send_item(1'b0, 32'd10, 32'd10, 3'd0, 31'd0, 31'd0);
      drain();
      write_reg(twe_pkg::CSR_TIME_SCALE, 31'd65535);
      write_reg(twe_pkg::CSR_EVENT_LIMIT, 31'd3);
      send_item(1'b0, 32'd0, 32'h7FFF_FFFF, 3'd0, 31'd0, 31'd0);
      send_item(1'b0, 32'd0, 32'd20, 3'd0, 31'd0, 31'd0);
      drain();
      write_reg(twe_pkg::CSR_EVENT_LIMIT, 31'd0);
      write_reg(twe_pkg::CSR_TIME_SCALE, 31'd0);
      send_item(1'b0, 32'd0, 32'd40, 3'd0, 31'd0, 31'd0);
      drain();
      write_reg(twe_pkg::CSR_EVENT_LIMIT, 31'd31);
      write_reg(twe_pkg::CSR_LOOP_MODE, 31'd1);
      write_reg(twe_pkg::CSR_CYCLE_LENGTH, 31'd50);
      send_item(1'b0, 32'd45, 32'd62, 3'd0, 31'd0, 31'd0);
      send_item(1'b0, 32'd20, 32'd49, 3'd0, 31'd0, 31'd0);
      send_item(1'b0, 32'd100, 32'd135, 3'd0, 31'd0, 31'd0);
      drain();

      // random phases with varying settings and idling
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         span = (ph % 2) ? 2000 : 200000;
         write_reg(twe_pkg::CSR_LOOP_MODE, 31'($urandom_range(1)));
         write_reg(twe_pkg::CSR_CYCLE_LENGTH, (ph == 7) ? 31'h7FFF_FFFF :
            31'(($urandom_range(3) == 0) ? 0 : $urandom_range(span, 1)));
         write_reg(twe_pkg::CSR_WINDOWS_IN_USE, (ph == 0) ? 31'd8 : 31'($urandom_range(15)));
         write_reg(twe_pkg::CSR_EVENT_LIMIT, (ph == 5) ? 31'd1 : 31'($urandom_range(20)));
         write_reg(twe_pkg::CSR_TIME_SCALE, (ph == 6) ? 31'd65535 :
            31'($urandom_range(1) ? 4096 : $urandom_range(65535)));
         load_random_windows(span);
         for (int k = 0; k < 10; k++) begin
            if ($urandom_range(5) == 0)
               send_item(1'b1, $urandom, $urandom, 3'($urandom_range(7)),
                  31'($urandom_range(span)), 31'($urandom_range(span / 2)));
            else
               send_item(1'b0, rand_time(span), rand_time(span), 3'($urandom),
                  31'($urandom), 31'($urandom));
         end
         // sender holds off until every event is back
         if (ph == 3) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (pending_events != 0) @(posedge clock);
         end
         drain();
      end

      if (fail_count == 0)
         $display("timeline_window_event_generator regression: pass");
      else
         $display("timeline_window_event_generator regression: fail");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+hdl
hdl/twe_pkg.sv
hdl/twe_channels.sv
hdl/twe_front.sv
hdl/twe_fifo.sv
hdl/twe_back.sv
hdl/timeline_window_event_generator.sv
sim/twe_event_checker.sv
sim/tb_timeline_window_event_generator.sv
